### rtl/lsrc_pkg.sv
package lsrc_pkg;
	localparam int CoordW = 16;
	localparam int ExtW = 18;
	localparam int ProdW = 36;
	localparam int MaxRounds = 8;
	localparam int RoundW = $clog2(MaxRounds + 1);

	localparam logic [1:0] RegLeft = 2'd0;
	localparam logic [1:0] RegTop = 2'd1;
	localparam logic [1:0] RegWidth = 2'd2;
	localparam logic [1:0] RegHeight = 2'd3;

	localparam logic [3:0] OcLeft = 4'b0001;
	localparam logic [3:0] OcRight = 4'b0010;
	localparam logic [3:0] OcTop = 4'b0100;
	localparam logic [3:0] OcBottom = 4'b1000;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic code;
		logic mul;
		logic div_start;
		logic upd;
	} lsrc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic all_in;
		logic shared;
		logic div_done;
	} lsrc_sts_t;
endpackage

### rtl/line_segment_rect_clipper.sv
// Cohen-Sutherland line clipper against a configured inclusive rectangle.
// Slave beat: s_tdata = {end_y, end_x, start_y, start_x}, one segment.
// Master beat: m_tdata = clipped endpoints in the same layout,
// m_tuser = rejected flag.
// Configuration: cfg_we/cfg_index/cfg_data write clip_left (0), clip_top (1),
// clip_width (2), clip_height (3); write only while idle.
// One segment is in work at a time. A clip round runs check, product,
// a 36-step bit-serial divide plus its done strobe, and the outcode
// update. A segment takes up to 8 rounds; an empty rectangle is rejected
// without any round. The block is occupied until its result is taken,
// including any output stall.
// Reset zeroes the configuration registers (empty rectangle rejects all lines)
// and returns the sequencer to idle. A result is held in the output
// register until m_tready; no new segment is taken before that.
module line_segment_rect_clipper (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,  // start_x, start_y, end_x, end_y
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata,  // out_start_x, out_start_y, out_end_x, out_end_y
	output logic m_tuser          // rejected
);
	import lsrc_pkg::*;

	lsrc_cmd_t cmd;
	lsrc_sts_t sts;

	lsrc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser),
		.cmd(cmd), .sts(sts)
	);

	lsrc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_data(s_tdata), .cmd(cmd), .sts(sts),
		.pts(m_tdata)
	);
endmodule

### rtl/lsrc_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module lsrc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [lsrc_pkg::ProdW-1:0] num,
	input  logic signed [lsrc_pkg::ExtW-1:0] den,
	output logic done,
	output logic signed [lsrc_pkg::ProdW-1:0] quo
);
	import lsrc_pkg::*;
	localparam int CntW = $clog2(ProdW + 1);

	logic [ProdW-1:0] q_q;
	logic [ProdW:0] rem_q;
	logic [ExtW-1:0] d_q;
	logic neg_q, busy_q, zero_q;
	logic [CntW-1:0] cnt_q;
	logic [ProdW:0] trial;
	logic [ProdW:0] sub;

	assign trial = {rem_q[ProdW-1:0], q_q[ProdW-1]};
	assign sub = trial - {{(ProdW+1-ExtW){1'b0}}, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(ProdW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num[ProdW-1] ? ProdW'(-num) : num;
			d_q <= den[ExtW-1] ? ExtW'(-den) : den;
			zero_q <= (den == '0);
			neg_q <= num[ProdW-1] ^ den[ExtW-1];
			rem_q <= '0;
		end else if (busy_q) begin
			if (!sub[ProdW]) begin
				rem_q <= sub;
				q_q <= {q_q[ProdW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[ProdW-2:0], 1'b0};
			end
		end
	end

	assign quo = zero_q ? '0 : (neg_q ? ProdW'(-q_q) : q_q);
endmodule

### rtl/lsrc_datapath.sv
// Endpoint registers, outcodes, edge product and the shared divider.
module lsrc_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [63:0] in_data,
	input  lsrc_pkg::lsrc_cmd_t cmd,
	output lsrc_pkg::lsrc_sts_t sts,
	output logic [63:0] pts
);
	import lsrc_pkg::*;

	logic signed [CoordW-1:0] left_q, top_q, wid_q, hgt_q;
	logic signed [ExtW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [ExtW-1:0] right_q, bottom_q;
	logic [3:0] c1_q, c2_q;
	logic sel_q;
	logic [3:0] bit_q;
	logic signed [ExtW-1:0] edge_q, base_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [ExtW-1:0] den_q;
	logic signed [ProdW-1:0] quo;
	logic div_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			top_q <= '0;
			wid_q <= '0;
			hgt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLeft: left_q <= cfg_data;
				RegTop: top_q <= cfg_data;
				RegWidth: wid_q <= cfg_data;
				RegHeight: hgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [3:0] ocode(input logic signed [ExtW-1:0] x,
		input logic signed [ExtW-1:0] y, input logic signed [ExtW-1:0] l,
		input logic signed [ExtW-1:0] r, input logic signed [ExtW-1:0] t,
		input logic signed [ExtW-1:0] b);
		logic [3:0] c;
		c = '0;
		if (x < l) c = OcLeft;
		else if (x > r) c = OcRight;
		if (y < t) c = c | OcTop;
		else if (y > b) c = c | OcBottom;
		return c;
	endfunction

	logic [3:0] csel, low;
	logic signed [ExtW-1:0] dx, dy, lx, ty;
	assign lx = ExtW'(left_q);
	assign ty = ExtW'(top_q);
	assign dx = x2_q - x1_q;
	assign dy = y2_q - y1_q;
	assign csel = (c1_q != '0) ? c1_q : c2_q;
	assign low = csel & (~csel + 4'd1);

	lsrc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(prod_q), .den(den_q), .done(div_done), .quo(quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= ExtW'($signed(in_data[15:0]));
			y1_q <= ExtW'($signed(in_data[31:16]));
			x2_q <= ExtW'($signed(in_data[47:32]));
			y2_q <= ExtW'($signed(in_data[63:48]));
			right_q <= lx + ExtW'(wid_q) - ExtW'(1);
			bottom_q <= ty + ExtW'(hgt_q) - ExtW'(1);
		end
		if (cmd.code) begin
			c1_q <= ocode(x1_q, y1_q, lx, right_q, ty, bottom_q);
			c2_q <= ocode(x2_q, y2_q, lx, right_q, ty, bottom_q);
		end
		// pick point and edge, form (edge - q) * d1
		if (cmd.mul) begin
			sel_q <= (c1_q == '0);
			bit_q <= low;
			if (low == OcLeft || low == OcRight) begin
				edge_q <= (low == OcLeft) ? lx : right_q;
				base_q <= (c1_q != '0) ? y1_q : y2_q;
				prod_q <= ProdW'(((low == OcLeft) ? lx : right_q)
					- ((c1_q != '0) ? x1_q : x2_q)) * ProdW'(dy);
				den_q <= dx;
			end else begin
				edge_q <= (low == OcTop) ? ty : bottom_q;
				base_q <= (c1_q != '0) ? x1_q : x2_q;
				prod_q <= ProdW'(((low == OcTop) ? ty : bottom_q)
					- ((c1_q != '0) ? y1_q : y2_q)) * ProdW'(dx);
				den_q <= dy;
			end
		end
		if (cmd.upd) begin
			if (bit_q == OcLeft || bit_q == OcRight) begin
				if (!sel_q) begin x1_q <= edge_q; y1_q <= base_q + ExtW'(quo); end
				else begin x2_q <= edge_q; y2_q <= base_q + ExtW'(quo); end
			end else begin
				if (!sel_q) begin y1_q <= edge_q; x1_q <= base_q + ExtW'(quo); end
				else begin y2_q <= edge_q; x2_q <= base_q + ExtW'(quo); end
			end
		end
	end

	assign sts.empty = (wid_q <= 0) || (hgt_q <= 0);
	assign sts.all_in = (c1_q | c2_q) == '0;
	assign sts.shared = (c1_q & c2_q) != '0;
	assign sts.div_done = div_done;
	assign pts = {y2_q[15:0], x2_q[15:0], y1_q[15:0], x1_q[15:0]};
endmodule

### rtl/lsrc_ctrl.sv
// Round sequencer and output register.
module lsrc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output logic m_tuser,
	output lsrc_pkg::lsrc_cmd_t cmd,
	input  lsrc_pkg::lsrc_sts_t sts
);
	import lsrc_pkg::*;

	typedef enum logic [2:0] {IDLE, CODE, CHECK, MUL, DIV, UPD, DONE} state_t;
	state_t st_q;
	logic [RoundW-1:0] rnd_q;

	assign s_tready = (st_q == IDLE);
	assign m_tvalid = (st_q == DONE);

	always_comb begin
		cmd = '0;
		cmd.load = (st_q == IDLE) && s_tvalid;
		cmd.code = (st_q == CODE) || (st_q == UPD);
		cmd.mul = (st_q == CHECK) && !sts.all_in && !sts.shared
			&& (rnd_q < RoundW'(MaxRounds));
		cmd.div_start = (st_q == MUL);
		cmd.upd = (st_q == DIV) && sts.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			rnd_q <= '0;
			m_tuser <= 1'b0;
		end else begin
			unique case (st_q)
				IDLE: if (s_tvalid) begin
					rnd_q <= '0;
					st_q <= CODE;
				end
				CODE: if (sts.empty) begin
					m_tuser <= 1'b1;
					st_q <= DONE;
				end else st_q <= CHECK;
				CHECK: begin
					if (sts.all_in) begin
						m_tuser <= 1'b0;
						st_q <= DONE;
					end else if (sts.shared || rnd_q >= RoundW'(MaxRounds)) begin
						m_tuser <= 1'b1;
						st_q <= DONE;
					end else st_q <= MUL;
				end
				MUL: st_q <= DIV;
				DIV: if (sts.div_done) st_q <= UPD;
				UPD: begin
					rnd_q <= rnd_q + 1'b1;
					st_q <= CHECK;
				end
				DONE: if (m_tready) st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

### test/tb_line_segment_rect_clipper.sv
module tb_line_segment_rect_clipper;
	timeunit 1ns;
	timeprecision 1ps;
	import lsrc_pkg::*;

	localparam int CapRounds = MaxRounds;
	localparam longint CycleLimit = 3000000;

	typedef struct packed {
		logic signed [15:0] ey;
		logic signed [15:0] ex;
		logic signed [15:0] sy;
		logic signed [15:0] sx;
	} seg_t;

	typedef struct {
		logic rej;
		seg_t seg;
	} clip_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = RegLeft;
	logic [15:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tuser;

	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_off = 0;
	longint cycles = 0;

	always #6 clk = ~clk;

	line_segment_rect_clipper dut (.*);

	// clipping rectangle and result queue
	class clip_board;
		longint left, top, wid, hgt;
		clip_t pend[$];
		int errors;

		function new();
			left = 0; top = 0; wid = 0; hgt = 0; errors = 0;
		endfunction

		function logic [3:0] region(longint x, longint y);
			logic [3:0] c;
			c = '0;
			if (x < left) c = OcLeft;
			else if (x > left + wid - 1) c = OcRight;
			if (y < top) c |= OcTop;
			else if (y > top + hgt - 1) c |= OcBottom;
			return c;
		endfunction

		function longint qdiv(longint n, longint d);
			return (d == 0) ? 0 : n / d;
		endfunction

		// project point onto edge of its lowest outcode bit
		function void shift_pt(logic [3:0] c, inout longint x, inout longint y,
				input longint dx, input longint dy);
			longint rgt, bot;
			rgt = left + wid - 1;
			bot = top + hgt - 1;
			if (c & OcLeft) begin
				y = y + qdiv((left - x) * dy, dx); x = left;
			end else if (c & OcRight) begin
				y = y + qdiv((rgt - x) * dy, dx); x = rgt;
			end else if (c & OcTop) begin
				x = x + qdiv((top - y) * dx, dy); y = top;
			end else if (c & OcBottom) begin
				x = x + qdiv((bot - y) * dx, dy); y = bot;
			end
		endfunction

		function void note_segment(seg_t s);
			longint x1, y1, x2, y2;
			logic [3:0] c1, c2;
			int n;
			clip_t r;
			x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
			r.rej = 1'b0;
			if (wid <= 0 || hgt <= 0) begin
				r.rej = 1'b1;
			end else begin
				c1 = region(x1, y1);
				c2 = region(x2, y2);
				n = 0;
				while ((c1 | c2) != 0) begin
					if ((c1 & c2) != 0 || n >= CapRounds) begin
						r.rej = 1'b1;
						break;
					end
					if (c1 != 0) begin
						shift_pt(c1, x1, y1, x2 - x1, y2 - y1);
						c1 = region(x1, y1);
					end else begin
						shift_pt(c2, x2, y2, x2 - x1, y2 - y1);
						c2 = region(x2, y2);
					end
					n++;
				end
			end
			r.seg.sx = x1[15:0]; r.seg.sy = y1[15:0];
			r.seg.ex = x2[15:0]; r.seg.ey = y2[15:0];
			pend.push_back(r);
		endfunction

		function void check_clip(logic rej, logic [63:0] d);
			clip_t e;
			seg_t a;
			a = d;
			if (pend.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h rej %b", d, rej);
				return;
			end
			e = pend.pop_front();
			if (e.rej !== rej || e.seg !== a) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp rej %b seg %h, got rej %b seg %h",
						e.rej, e.seg, rej, a);
			end
		endfunction
	endclass

	clip_board sb = new();

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off when requested
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_clip(m_tuser, m_tdata);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// write enable stays high between back-to-back writes
	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		case (idx)
			RegLeft: sb.left = longint'($signed(v));
			RegTop: sb.top = longint'($signed(v));
			RegWidth: sb.wid = longint'($signed(v));
			default: sb.hgt = longint'($signed(v));
		endcase
	endtask

	task automatic set_rect(logic [15:0] l, logic [15:0] t, logic [15:0] w,
			logic [15:0] h);
		write_reg(RegLeft, l);
		write_reg(RegTop, t);
		write_reg(RegWidth, w);
		write_reg(RegHeight, h);
		cfg_we <= 1'b0;
	endtask

	// wait for all results, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pend.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// valid stays high after a beat unless the sender idles or drains
	task automatic send_seg(seg_t s);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_segment(s);
	endtask

	function automatic logic [15:0] rnd_coord(longint lo, longint span);
		longint v;
		case ($urandom_range(9))
			0: v = $signed(16'($urandom));
			1: v = $urandom_range(1) ? 32767 : -32768;
			default: v = lo - span / 2 + $urandom_range(2 * span);
		endcase
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	task automatic random_run(int n);
		seg_t s;
		longint sp;
		for (int i = 0; i < n; i++) begin
			sp = (sb.wid > 0) ? sb.wid : 100;
			s.sx = rnd_coord(sb.left + sp / 2, sp * 2);
			s.ex = rnd_coord(sb.left + sp / 2, sp * 2);
			sp = (sb.hgt > 0) ? sb.hgt : 100;
			s.sy = rnd_coord(sb.top + sp / 2, sp * 2);
			s.ey = rnd_coord(sb.top + sp / 2, sp * 2);
			send_seg(s);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: empty rectangle
		send_seg({16'sd5, 16'sd5, 16'sd1, 16'sd1});
		drain();
		set_rect(16'sd10, 16'sd20, 16'sd100, 16'sd50);
		// inside, crossing each edge, shared bit, diagonal through corners
		send_seg({16'sd30, 16'sd50, 16'sd25, 16'sd15});
		send_seg({16'sd40, 16'sd50, 16'sd40, -16'sd200});
		send_seg({16'sd40, 16'sd500, 16'sd40, 16'sd50});
		send_seg({16'sd500, 16'sd50, -16'sd500, 16'sd50});
		send_seg({16'sd30, -16'sd5, 16'sd40, -16'sd50});
		send_seg({16'sd900, 16'sd900, -16'sd900, -16'sd900});
		send_seg({16'sd10, 16'sd300, 16'sd60, -16'sd300});
		send_seg({-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767});
		send_seg({16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767});
		send_seg({16'sd69, 16'sd109, 16'sd20, 16'sd10});
		send_seg({16'sd21, 16'sd111, 16'sd68, 16'sd8});
		drain();
		set_rect(16'sd0, 16'sd0, -16'sd5, 16'sd10);
		send_seg({16'sd1, 16'sd1, 16'sd2, 16'sd2});
		drain();
		set_rect(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		send_seg({16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768});
		send_seg({-16'sd1, 16'sd32767, 16'sd100, -16'sd32768});
		drain();
		set_rect(16'sd3, 16'sd3, 16'sd1, 16'sd1);
		send_seg({16'sd3, 16'sd3, 16'sd3, 16'sd3});
		send_seg({16'sd9, 16'sd7, -16'sd4, -16'sd2});
		drain();

		// random phases with varied rectangles and idling
		for (int ph = 0; ph < 6; ph++) begin
			snd_idle = (ph % 3 == 0) ? 28 : (ph % 3 == 1) ? 50 : 0;
			rcv_idle = (ph % 3 == 0) ? 50 : (ph % 3 == 1) ? 28 : 0;
			set_rect(16'($urandom_range(2000) - 1000), 16'($urandom_range(2000) - 1000),
				16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
			if (ph == 2) begin
				fork
					hold_off = 3000;
					random_run(20);
				join
			end
			random_run(300);
			drain();
		end

		if (sb.errors == 0 && sb.pend.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### line_segment_rect_clipper.f
rtl/lsrc_pkg.sv
rtl/lsrc_div.sv
rtl/lsrc_datapath.sv
rtl/lsrc_ctrl.sv
rtl/line_segment_rect_clipper.sv
test/tb_line_segment_rect_clipper.sv
